/* src/delimited_response_capture_defines.svh */
// assertion macros shared by the response capture block
`ifndef DELIMITED_RESPONSE_CAPTURE_DEFINES_SVH
`define DELIMITED_RESPONSE_CAPTURE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/drc_pkg.sv */
// types, constants and helpers for the delimited response capture block
package drc_pkg;

	localparam int BUFFER_SIZE = 256;
	localparam int MAX_PATTERN = 8;
	localparam int LEFT_W = $clog2(BUFFER_SIZE + 1);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN);
	localparam logic [LEFT_W-1:0] BUFFER_LEFT = LEFT_W'(BUFFER_SIZE);

	localparam logic OP_ARM = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic [1:0] REG_START_PATTERN = 2'd0;
	localparam logic [1:0] REG_START_LENGTH = 2'd1;
	localparam logic [1:0] REG_END_PATTERN = 2'd2;
	localparam logic [1:0] REG_END_LENGTH = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_START = 2'd1,
		PH_END = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_DONE = 2'd1,
		ST_OVF = 2'd2,
		ST_IDLE = 2'd3
	} status_t;

	typedef struct packed {
		logic opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic payload_valid;
		status_t status;
	} result_t;

	typedef struct packed {
		logic [63:0] start_pattern;
		logic [3:0] start_length;
		logic [63:0] end_pattern;
		logic [3:0] end_length;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic [3:0] match_index;
		logic [LEFT_W-1:0] bytes_left;
	} ctx_t;

	function automatic logic [3:0] clamp_len(logic [3:0] len);
		return (len > MAX_LEN) ? MAX_LEN : len;
	endfunction

endpackage

/* src/delimited_response_capture.sv */
// Delimited response capture top level. Each transaction is either an arm
// (opcode 0), which starts a new search, or one received byte (opcode 1).
// After an arm the block hunts for the start pattern, then echoes every
// following byte with payload_valid set until the end pattern has gone by,
// end pattern included. Every transaction yields exactly one result whose
// status reads busy, complete, overflow (drop the payload) or idle. One
// transaction is taken per clock while the result register is free or is
// being taken. The transaction waits in the input register, the match step
// runs on it there against the context register, and the result register
// holds the outcome until it is taken. A held result stalls the input
// register, so at most two transactions wait inside the block.
// Registers (64-bit apb, byte address 8*i): start_pattern,
// start_length, end_pattern, end_length; lengths above eight count as eight.
`include "delimited_response_capture_defines.svh"

module delimited_response_capture (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input drc_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output drc_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [drc_pkg::ADDR_W-1:0] paddr,
	input logic [drc_pkg::DATA_W-1:0] pwdata,
	output logic [drc_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	drc_pkg::cfg_t cfg;
	drc_pkg::ctx_t ctx_q;
	drc_pkg::ctx_t ctx_next;
	drc_pkg::item_t item_s1;
	logic valid_s1;
	drc_pkg::result_t step_result;
	drc_pkg::result_t result_s2;
	logic valid_s2;
	logic advance;

	assign pready = 1'b1;

	drc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	drc_matcher u_matcher (
		.cfg(cfg),
		.ctx(ctx_q),
		.item(item_s1),
		.ctx_next(ctx_next),
		.result(step_result)
	);

	assign advance = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	// match context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.phase <= drc_pkg::PH_IDLE;
			ctx_q.match_index <= '0;
			ctx_q.bytes_left <= '0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= step_result;
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

	`DRC_ASSERT_NOW(a_idle_index_clear, ctx_q.phase == drc_pkg::PH_IDLE, ctx_q.match_index == '0, "match index left set while idle")
	`DRC_ASSERT_NOW(a_index_in_range, 1'b1, ctx_q.match_index < drc_pkg::MAX_LEN, "match index beyond pattern length")
	`DRC_ASSERT_NOW(a_active_budget, ctx_q.phase != drc_pkg::PH_IDLE, ctx_q.bytes_left != '0, "active phase with no byte budget")
	`DRC_ASSERT_NOW(a_payload_status, valid_s2 && result_s2.payload_valid, result_s2.status != drc_pkg::ST_IDLE, "payload byte reported idle")
	`DRC_ASSERT_NEXT(a_step_lands, advance, valid_s2, "processed transaction lost before result register")

endmodule

/* src/drc_regs.sv */
// apb register file holding the start and end patterns and their lengths
module drc_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [drc_pkg::ADDR_W-1:0] paddr,
	input logic [drc_pkg::DATA_W-1:0] pwdata,
	output logic [drc_pkg::DATA_W-1:0] prdata,
	output drc_pkg::cfg_t cfg
);

	logic [63:0] start_pattern_q;
	logic [3:0] start_length_q;
	logic [63:0] end_pattern_q;
	logic [3:0] end_length_q;
	logic [1:0] reg_index;
	logic wr_en;

	assign reg_index = paddr[drc_pkg::ADDR_W-1:3];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pattern_q <= '0;
			start_length_q <= '0;
			end_pattern_q <= '0;
			end_length_q <= '0;
		end else if (wr_en) begin
			unique case (reg_index)
				drc_pkg::REG_START_PATTERN: start_pattern_q <= pwdata[63:0];
				drc_pkg::REG_START_LENGTH: start_length_q <= pwdata[3:0];
				drc_pkg::REG_END_PATTERN: end_pattern_q <= pwdata[63:0];
				drc_pkg::REG_END_LENGTH: end_length_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			drc_pkg::REG_START_PATTERN: prdata = start_pattern_q;
			drc_pkg::REG_START_LENGTH: prdata = {60'd0, start_length_q};
			drc_pkg::REG_END_PATTERN: prdata = end_pattern_q;
			drc_pkg::REG_END_LENGTH: prdata = {60'd0, end_length_q};
		endcase
	end

	assign cfg.start_pattern = start_pattern_q;
	assign cfg.start_length = start_length_q;
	assign cfg.end_pattern = end_pattern_q;
	assign cfg.end_length = end_length_q;

endmodule

/* src/drc_matcher.sv */
// combinational pattern match step: next context and result for one transaction
module drc_matcher (
	input drc_pkg::cfg_t cfg,
	input drc_pkg::ctx_t ctx,
	input drc_pkg::item_t item,
	output drc_pkg::ctx_t ctx_next,
	output drc_pkg::result_t result
);

	logic [3:0] start_span;
	logic [3:0] end_len;
	logic [3:0] cur_len;
	logic [63:0] cur_pattern;
	logic [7:0] pat_byte;
	logic [3:0] idx_inc;
	logic hit;
	logic complete;
	logic [drc_pkg::LEFT_W-1:0] left_dec;
	logic [drc_pkg::LEFT_W-1:0] end_left;
	logic exhausted;

	assign start_span = drc_pkg::clamp_len(cfg.start_length);
	assign end_len = drc_pkg::clamp_len(cfg.end_length);
	assign cur_len = (ctx.phase == drc_pkg::PH_END) ? end_len : start_span;
	assign cur_pattern = (ctx.phase == drc_pkg::PH_END) ? cfg.end_pattern : cfg.start_pattern;
	assign pat_byte = cur_pattern[{ctx.match_index[2:0], 3'b000} +: 8];
	assign idx_inc = ctx.match_index + 4'd1;
	assign hit = (item.rx_byte == pat_byte);
	assign complete = hit && (idx_inc >= cur_len);
	assign left_dec = (ctx.bytes_left != '0) ? ctx.bytes_left - drc_pkg::LEFT_W'(1)
		: ctx.bytes_left;
	assign exhausted = (left_dec == '0);
	assign end_left = drc_pkg::BUFFER_LEFT - drc_pkg::LEFT_W'(start_span);

	// next context
	always_comb begin
		ctx_next = ctx;
		if (item.opcode == drc_pkg::OP_ARM) begin
			ctx_next.match_index = '0;
			if (start_span != '0) begin
				ctx_next.phase = drc_pkg::PH_START;
				ctx_next.bytes_left = drc_pkg::BUFFER_LEFT;
			end else if (end_len == '0) begin
				ctx_next.phase = drc_pkg::PH_IDLE;
			end else begin
				ctx_next.phase = drc_pkg::PH_END;
				ctx_next.bytes_left = end_left;
			end
		end else begin
			unique case (ctx.phase)
				drc_pkg::PH_START, drc_pkg::PH_END: begin
					if (complete) begin
						ctx_next.match_index = '0;
						if (ctx.phase == drc_pkg::PH_END || end_len == '0) begin
							ctx_next.phase = drc_pkg::PH_IDLE;
						end else begin
							ctx_next.phase = drc_pkg::PH_END;
							ctx_next.bytes_left = end_left;
						end
					end else begin
						ctx_next.match_index = hit ? idx_inc : 4'd0;
						ctx_next.bytes_left = left_dec;
						if (exhausted) begin
							ctx_next.phase = drc_pkg::PH_IDLE;
							ctx_next.match_index = '0;
						end
					end
				end
				default: ctx_next.phase = drc_pkg::PH_IDLE;
			endcase
		end
	end

	// result fields
	always_comb begin
		result.data_byte = item.rx_byte;
		result.payload_valid = 1'b0;
		result.status = drc_pkg::ST_IDLE;
		if (item.opcode == drc_pkg::OP_ARM) begin
			result.data_byte = '0;
			result.status = (start_span == '0 && end_len == '0) ? drc_pkg::ST_DONE
				: drc_pkg::ST_BUSY;
		end else begin
			unique case (ctx.phase)
				drc_pkg::PH_START: begin
					if (complete)
						result.status = (end_len == '0) ? drc_pkg::ST_DONE : drc_pkg::ST_BUSY;
					else
						result.status = exhausted ? drc_pkg::ST_OVF : drc_pkg::ST_BUSY;
				end
				drc_pkg::PH_END: begin
					result.payload_valid = 1'b1;
					if (complete)
						result.status = drc_pkg::ST_DONE;
					else
						result.status = exhausted ? drc_pkg::ST_OVF : drc_pkg::ST_BUSY;
				end
				default: result.status = drc_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/delimited_response_capture_tb.sv */
// self-checking testbench for the delimited response capture block
`timescale 1ns / 100ps

module delimited_response_capture_tb;
	import drc_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam int PLAN_ROWS = 40;

	typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [1:0] reg_idx;
		logic [63:0] reg_val;
		item_t it;
		logic typed;
		result_t want;
	} plan_row_t;

	typedef struct packed {
		logic typed;
		result_t want;
	} row_check_t;

	localparam result_t NO_WANT = '{8'h00, 1'b0, ST_BUSY};

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	delimited_response_capture dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies and search state of the capture predictor
	logic [63:0] cfg_start_pat = '0;
	logic [3:0] cfg_start_cnt = '0;
	logic [63:0] cfg_end_pat = '0;
	logic [3:0] cfg_end_len = '0;
	phase_t resp_phase = PH_IDLE;
	logic [3:0] hit_index = '0;
	logic [LEFT_W-1:0] room_left = '0;

	result_t expected_results[$];
	row_check_t row_checks[$];

	int items_sent = 0;
	int results_seen = 0;
	int err_count = 0;
	int n_done = 0;
	int n_ovf = 0;
	int n_payload = 0;
	int n_reg_writes = 0;
	int idle_cycles = 0;
	bit hold_off_req = 1'b0;
	bit sender_burst = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		// registers at reset
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hAA}, 1'b1, '{8'hAA, 1'b0, ST_IDLE}},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_ARM, 8'h00}, 1'b1, '{8'h00, 1'b0, ST_DONE}},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h55}, 1'b1, '{8'h55, 1'b0, ST_IDLE}},
		// crlf start, ok-crlf end
		'{STEP_REG, REG_START_PATTERN, 64'h0A0D, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_START_LENGTH, 64'h2, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_END_PATTERN, 64'h0A0D4B4F, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_END_LENGTH, 64'h4, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_ARM, 8'h00}, 1'b1, '{8'h00, 1'b0, ST_BUSY}},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0D}, 1'b0, NO_WANT},
		// repeated first byte is not rechecked
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0D}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0D}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0A}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h4F}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h4B}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0D}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h0A}, 1'b1, '{8'h0A, 1'b1, ST_DONE}},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b1, '{8'hFF, 1'b0, ST_IDLE}},
		// all-ones start, saturated length, no end phase
		'{STEP_REG, REG_START_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_START_LENGTH, 64'hF, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_END_LENGTH, 64'h0, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_ARM, 8'hFF}, 1'b1, '{8'h00, 1'b0, ST_BUSY}},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'hFF}, 1'b1, '{8'hFF, 1'b0, ST_DONE}},
		// length lowered below progress while armed
		'{STEP_REG, REG_START_PATTERN, 64'h0706050403020100, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_START_LENGTH, 64'h8, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_END_PATTERN, 64'h0, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_REG, REG_END_LENGTH, 64'h1, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_ARM, 8'h5A}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h00}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h01}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h02}, 1'b0, NO_WANT},
		'{STEP_REG, REG_START_LENGTH, 64'h2, '{OP_ARM, 8'h00}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h03}, 1'b0, NO_WANT},
		'{STEP_ITEM, REG_START_PATTERN, 64'h0, '{OP_BYTE, 8'h00}, 1'b1, '{8'h00, 1'b1, ST_DONE}}
	};

	function automatic logic [3:0] eff_len(logic [3:0] l);
		return (l > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : l;
	endfunction

	function automatic bit pattern_hit(logic [63:0] pat, logic [3:0] len, logic [7:0] b);
		logic [7:0] next_byte;
		next_byte = pat[{hit_index[2:0], 3'b000} +: 8];
		if (b == next_byte) begin
			hit_index = hit_index + 4'd1;
			if (hit_index >= len) begin
				hit_index = '0;
				return 1'b1;
			end
		end else begin
			hit_index = '0;
		end
		return 1'b0;
	endfunction

	function automatic status_t open_end_phase();
		if (eff_len(cfg_end_len) == 4'd0) begin
			resp_phase = PH_IDLE;
			return ST_DONE;
		end
		resp_phase = PH_END;
		hit_index = '0;
		room_left = LEFT_W'(BUFFER_SIZE) - LEFT_W'(eff_len(cfg_start_cnt));
		return ST_BUSY;
	endfunction

	function automatic status_t spend_room();
		if (room_left != '0)
			room_left = room_left - LEFT_W'(1);
		if (room_left == '0) begin
			resp_phase = PH_IDLE;
			hit_index = '0;
			return ST_OVF;
		end
		return ST_BUSY;
	endfunction

	function automatic result_t capture_step(item_t it);
		result_t r;
		r.data_byte = it.rx_byte;
		r.payload_valid = 1'b0;
		r.status = ST_IDLE;
		if (it.opcode == OP_ARM) begin
			r.data_byte = 8'h00;
			hit_index = '0;
			if (eff_len(cfg_start_cnt) != 4'd0) begin
				resp_phase = PH_START;
				room_left = LEFT_W'(BUFFER_SIZE);
				r.status = ST_BUSY;
			end else begin
				r.status = open_end_phase();
			end
		end else if (resp_phase == PH_START) begin
			if (pattern_hit(cfg_start_pat, eff_len(cfg_start_cnt), it.rx_byte))
				r.status = open_end_phase();
			else
				r.status = spend_room();
		end else if (resp_phase == PH_END) begin
			r.payload_valid = 1'b1;
			if (pattern_hit(cfg_end_pat, eff_len(cfg_end_len), it.rx_byte)) begin
				resp_phase = PH_IDLE;
				r.status = ST_DONE;
			end else begin
				r.status = spend_room();
			end
		end else begin
			resp_phase = PH_IDLE;
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		err_count++;
	endtask

	// prediction on input transactions, comparison on output transactions
	always @(posedge clk) begin : scoreboard
		result_t want;
		row_check_t rc;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				want = capture_step(item);
				if (row_checks.size() != 0) begin
					rc = row_checks.pop_front();
					if (rc.typed)
						want = rc.want;
				end
				if (want.status == ST_DONE)
					n_done++;
				if (want.status == ST_OVF)
					n_ovf++;
				if (want.payload_valid)
					n_payload++;
				expected_results.push_back(want);
			end
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					flag_error($sformatf("result %02h/%0b/%0d with nothing expected",
						result.data_byte, result.payload_valid, result.status));
				end else begin
					want = expected_results.pop_front();
					if (result.data_byte !== want.data_byte)
						flag_error($sformatf("data_byte %02h, expected %02h",
							result.data_byte, want.data_byte));
					if (result.payload_valid !== want.payload_valid)
						flag_error($sformatf("payload_valid %0b, expected %0b",
							result.payload_valid, want.payload_valid));
					if (result.status !== want.status)
						flag_error($sformatf("status %0d, expected %0d",
							result.status, want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("delimited_response_capture_tb: errors");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver side: random back-pressure, one long hold-off on request
	initial begin
		int wait_n;
		int run_n;
		wait_n = 0;
		run_n = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				wait_n = LONG_HOLD;
			end
			if (wait_n > 0) begin
				result_ready <= 1'b0;
				wait_n--;
			end else begin
				result_ready <= 1'b1;
				if (run_n > 0)
					run_n--;
				else if ($urandom_range(0, 9) == 0)
					run_n = $urandom_range(30, 120);
				else
					wait_n = pick_gap();
			end
		end
	end

	task automatic offer(input item_t it, input logic typed, input result_t want);
		int gap;
		gap = sender_burst ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_checks.push_back('{typed, want});
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		offer(item_t'{OP_BYTE, b}, 1'b0, NO_WANT);
	endtask

	task automatic send_arm();
		offer(item_t'{OP_ARM, 8'($urandom)}, 1'b0, NO_WANT);
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != items_sent)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_START_PATTERN: cfg_start_pat = val;
			REG_START_LENGTH: cfg_start_cnt = val[3:0];
			REG_END_PATTERN: cfg_end_pat = val;
			REG_END_LENGTH: cfg_end_len = val[3:0];
		endcase
		n_reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_pattern();
		logic [63:0] p;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 6)
			return {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 4))
				0: p[8*i +: 8] = 8'h0D;
				1: p[8*i +: 8] = 8'h0A;
				2: p[8*i +: 8] = 8'h4F;
				3: p[8*i +: 8] = 8'h4B;
				default: p[8*i +: 8] = 8'($urandom);
			endcase
		end
		return p;
	endfunction

	function automatic logic [3:0] random_length(bit nonzero);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return nonzero ? 4'd1 : 4'd0;
		if (r == 1)
			return 4'd15;
		if (r == 2)
			return 4'd8;
		if (r == 3)
			return 4'($urandom_range(9, 14));
		return 4'($urandom_range(1, 8));
	endfunction

	task automatic new_settings(input bit nonzero);
		logic [63:0] sp;
		logic [63:0] ep;
		logic [3:0] sl;
		logic [3:0] el;
		sp = random_pattern();
		ep = random_pattern();
		sl = random_length(nonzero);
		el = random_length(nonzero);
		drain();
		reg_write(REG_START_PATTERN, sp);
		reg_write(REG_START_LENGTH, {60'($urandom), sl});
		reg_write(REG_END_PATTERN, ep);
		reg_write(REG_END_LENGTH, {60'($urandom), el});
	endtask

	// mostly delimiter bytes, so partial matches are frequent
	function automatic logic [7:0] stream_byte();
		int r;
		logic [2:0] k;
		r = $urandom_range(0, 9);
		k = 3'($urandom_range(0, 7));
		if (r < 4)
			return cfg_start_pat[{k, 3'b000} +: 8];
		if (r < 7)
			return cfg_end_pat[{k, 3'b000} +: 8];
		return 8'($urandom);
	endfunction

	task automatic send_delimiter(input logic [63:0] pat, input logic [3:0] len);
		int n;
		int cut;
		n = eff_len(len);
		if (n > 0 && $urandom_range(0, 5) == 0) begin
			cut = $urandom_range(0, n - 1);
			for (int i = 0; i < cut; i++)
				send_byte(pat[8*i +: 8]);
			send_byte(stream_byte());
		end
		for (int i = 0; i < n; i++)
			send_byte(pat[8*i +: 8]);
	endtask

	task automatic send_response();
		int n;
		send_arm();
		n = $urandom_range(0, 5);
		repeat (n) send_byte(stream_byte());
		send_delimiter(cfg_start_pat, cfg_start_cnt);
		n = $urandom_range(0, 10);
		repeat (n) send_byte(stream_byte());
		if ($urandom_range(0, 14) != 0)
			send_delimiter(cfg_end_pat, cfg_end_len);
		n = $urandom_range(0, 2);
		repeat (n) send_byte(8'($urandom));
	endtask

	// bytes that never advance the match, so the phase runs out of room
	task automatic overrun(input bit in_end_phase);
		logic [7:0] avoid;
		logic [7:0] b;
		send_arm();
		if (in_end_phase) begin
			send_delimiter(cfg_start_pat, cfg_start_cnt);
			avoid = cfg_end_pat[7:0];
		end else begin
			avoid = cfg_start_pat[7:0];
		end
		repeat (BUFFER_SIZE) begin
			b = 8'($urandom);
			if (b == avoid)
				b = ~b;
			send_byte(b);
		end
	endtask

	initial begin
		int resp;
		int target;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG) begin
				drain();
				reg_write(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				offer(plan[i].it, plan[i].typed, plan[i].want);
			end
		end

		drain();
		target = items_sent + RANDOM_ITEMS;
		resp = 0;
		new_settings(1'b1);
		while (items_sent < target) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			if (resp == 2) begin
				overrun(1'b0);
			end else if (resp == 5) begin
				overrun(1'b1);
			end else if (resp > 5 && $urandom_range(0, 79) == 0) begin
				overrun(1'($urandom));
			end else begin
				if (resp == 8)
					hold_off_req = 1'b1;
				send_response();
			end
			resp++;
			if (resp % 10 == 0)
				new_settings(1'b0);
			else if ($urandom_range(0, 7) == 0)
				drain();
		end

		sender_burst = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("%0d transactions in, %0d results checked, %0d register writes",
			items_sent, results_seen, n_reg_writes);
		$display("%0d responses complete, %0d overflows, %0d payload bytes",
			n_done, n_ovf, n_payload);
		if (err_count == 0)
			$display("delimited_response_capture_tb: clean");
		else
			$display("delimited_response_capture_tb: errors");
		$finish;
	end

endmodule
